// ===== sv/tlb_page_table_translator_macros.svh =====
// Assertion macros for the address translator.
// Used by the top level; the macros assume signals named clk and rst in scope.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLBPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("translator check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLBPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("translator check failed");

`endif

// ===== sv/tlbpt_pkg.sv =====
// Shared types for the address translator: sequencer states and outcome codes.
// No dependencies.
package tlbpt_pkg;

  localparam int ADDR_WIDTH    = 16;
  localparam int OUTCOME_WIDTH = 2;
  localparam int TOTAL_WIDTH   = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_LOOKUP
  } tlbpt_state_t;

  typedef enum logic [OUTCOME_WIDTH-1:0] {
    OC_TLB_HIT  = 2'd0,
    OC_MAP_HIT  = 2'd1,
    OC_FAULT    = 2'd2,
    OC_NO_FRAME = 2'd3
  } tlbpt_outcome_t;

endpackage

// ===== sv/tlbpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tlb_page_table_translator.sv =====
// Demand-paging address translator with a FIFO-replaced TLB and a page map in RAM.
// Depends on tlbpt_pkg, tlbpt_ram and tlb_page_table_translator_macros.svh.
//
//   channel  dir  signals
//   request  in   in_valid, in_stall, virt_addr
//   result   out  out_valid, out_stall, phys_addr, outcome, tlb_hit_total, fault_total
//
// A request goes through the page-map RAM read (after an index state that reduces the
// page number when PAGE_COUNT is not a power of two), then the TLB compare, page-map
// write-back and result load.
// After reset every page-map entry is cleared while in_stall is high.
// A result held by out_stall holds the next lookup; no new request is taken meanwhile.
`include "tlb_page_table_translator_macros.svh"

module tlb_page_table_translator
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES  = 16,
  parameter int PAGE_COUNT   = 256,
  parameter int FRAME_COUNT  = 256,
  parameter int OFFSET_WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ADDR_WIDTH-1:0]    virt_addr,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ADDR_WIDTH-1:0]    phys_addr,
  output logic [OUTCOME_WIDTH-1:0] outcome,
  output logic [TOTAL_WIDTH-1:0]   tlb_hit_total,
  output logic [TOTAL_WIDTH-1:0]   fault_total
);

  localparam int PW  = $clog2(PAGE_COUNT);
  localparam int FIW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int NFW = $clog2(FRAME_COUNT + 1);
  localparam int TW  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int MW  = FIW + 1;
  localparam bit PAGE_POW2 = (PAGE_COUNT == (1 << PW));
  localparam int RECIP_SHIFT = 24;
  localparam longint RECIP =
    ((longint'(1) << RECIP_SHIFT) + longint'(PAGE_COUNT) - 1) / longint'(PAGE_COUNT);
  localparam logic [ADDR_WIDTH-1:0] OFF_MASK =
    ADDR_WIDTH'((32'd1 << OFFSET_WIDTH) - 32'd1);

  tlbpt_state_t state, state_next;
  logic [PW-1:0] clr_addr;

  logic [ADDR_WIDTH-1:0] addr_q;
  logic [ADDR_WIDTH-1:0] raw_q;
  logic [ADDR_WIDTH-1:0] quot_q;
  logic [PW-1:0]         page_q;

  logic [ADDR_WIDTH-1:0] raw_in;
  logic [47:0]           quot_prod;
  logic [ADDR_WIDTH-1:0] quot_in;
  logic [PW-1:0]         page_in_pow;
  logic [PW-1:0]         page_mod;

  logic          ram_we, ram_re;
  logic [PW-1:0] ram_waddr, ram_raddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [PW-1:0]          tlb_page  [TLB_ENTRIES];
  logic [FIW-1:0]         tlb_frame [TLB_ENTRIES];
  logic [TW-1:0]          tlb_ptr;
  logic                   tlb_hit;
  logic [FIW-1:0]         tlb_hit_frame;
  logic                   tlb_insert;

  logic [NFW-1:0]         next_free;
  logic [TOTAL_WIDTH-1:0] tlb_hit_count, tlb_hit_count_next;
  logic [TOTAL_WIDTH-1:0] fault_count, fault_count_next;

  logic                   lookup_fire;
  logic                   map_valid;
  logic [FIW-1:0]         map_frame;
  logic [FIW-1:0]         alloc_frame;
  tlbpt_outcome_t         res_outcome;
  logic [FIW-1:0]         res_frame;
  logic                   res_fault;
  logic [31:0]            phys_wide;
  logic [ADDR_WIDTH-1:0]  res_phys;

  assign raw_in      = ADDR_WIDTH'(virt_addr >> OFFSET_WIDTH);
  assign quot_prod   = 48'(raw_in) * 48'(RECIP);
  assign quot_in     = ADDR_WIDTH'(quot_prod >> RECIP_SHIFT);
  assign page_in_pow = raw_in[PW-1:0];
  assign page_mod    = PW'(raw_q - ADDR_WIDTH'(quot_q * ADDR_WIDTH'(PAGE_COUNT)));

  tlbpt_ram #(
    .WIDTH(MW),
    .DEPTH(PAGE_COUNT)
  ) u_page_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    tlb_hit       = 1'b0;
    tlb_hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && tlb_page[i] == page_q) begin
        tlb_hit       = 1'b1;
        tlb_hit_frame = tlb_frame[i];
      end
    end
  end

  assign map_valid   = ram_rdata[MW-1];
  assign map_frame   = ram_rdata[FIW-1:0];
  assign alloc_frame = next_free[FIW-1:0];

  always_comb begin
    res_outcome        = OC_NO_FRAME;
    res_frame          = '0;
    res_fault          = 1'b0;
    tlb_hit_count_next = tlb_hit_count;
    fault_count_next   = fault_count;
    if (tlb_hit) begin
      res_outcome        = OC_TLB_HIT;
      res_frame          = tlb_hit_frame;
      tlb_hit_count_next = tlb_hit_count + 1'b1;
    end else if (map_valid) begin
      res_outcome = OC_MAP_HIT;
      res_frame   = map_frame;
    end else if (next_free < NFW'(FRAME_COUNT)) begin
      res_outcome      = OC_FAULT;
      res_frame        = alloc_frame;
      res_fault        = 1'b1;
      fault_count_next = fault_count + 1'b1;
    end
    phys_wide = (32'(res_frame) << OFFSET_WIDTH) | 32'(addr_q & OFF_MASK);
    res_phys  = (res_outcome == OC_NO_FRAME) ? '0 : phys_wide[ADDR_WIDTH-1:0];
  end

  assign tlb_insert = lookup_fire &&
                      (res_outcome == OC_MAP_HIT || res_outcome == OC_FAULT);

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    ram_re      = 1'b0;
    ram_raddr   = page_in_pow;
    ram_we      = 1'b0;
    ram_waddr   = clr_addr;
    ram_wdata   = '0;
    lookup_fire = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == PW'(PAGE_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (PAGE_POW2) begin
            ram_re     = 1'b1;
            state_next = ST_LOOKUP;
          end else begin
            state_next = ST_INDEX;
          end
        end
      end
      ST_INDEX: begin
        ram_re     = 1'b1;
        ram_raddr  = page_mod;
        state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!out_valid || !out_stall) begin
          lookup_fire = 1'b1;
          state_next  = ST_IDLE;
          if (res_fault) begin
            ram_we    = 1'b1;
            ram_waddr = page_q;
            ram_wdata = {1'b1, alloc_frame};
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      addr_q <= virt_addr;
      raw_q  <= raw_in;
      quot_q <= quot_in;
      page_q <= page_in_pow;
    end else if (state == ST_INDEX) begin
      page_q <= page_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid     <= '0;
      tlb_ptr       <= '0;
      next_free     <= '0;
      tlb_hit_count <= '0;
      fault_count   <= '0;
    end else if (lookup_fire) begin
      tlb_hit_count <= tlb_hit_count_next;
      fault_count   <= fault_count_next;
      if (res_fault) begin
        next_free <= next_free + 1'b1;
      end
      if (tlb_insert) begin
        tlb_valid[tlb_ptr] <= 1'b1;
        tlb_ptr <= (tlb_ptr == TW'(TLB_ENTRIES - 1)) ? '0 : tlb_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tlb_insert) begin
      tlb_page[tlb_ptr]  <= page_q;
      tlb_frame[tlb_ptr] <= res_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lookup_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_fire) begin
      phys_addr     <= res_phys;
      outcome       <= res_outcome;
      tlb_hit_total <= tlb_hit_count_next;
      fault_total   <= fault_count_next;
    end
  end

  `TLBPT_ASSERT_NOW(a_clear_stalls, state == ST_CLEAR, in_stall && !lookup_fire)
  `TLBPT_ASSERT_NEXT(a_fault_allocates, lookup_fire && res_fault,
                     next_free == $past(next_free) + 1'b1)
  `TLBPT_ASSERT_NOW(a_frames_bounded, 1'b1, next_free <= NFW'(FRAME_COUNT))
  `TLBPT_ASSERT_NOW(a_result_from_lookup, $rose(out_valid) && !$past(rst),
                    $past(state) == ST_LOOKUP)
  `TLBPT_ASSERT_NOW(a_hit_count_on_hit,
                    !$past(rst) && tlb_hit_count != $past(tlb_hit_count),
                    out_valid && outcome == OC_TLB_HIT)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for tlb_page_table_translator, built on tlbpt_pkg.
// A tracker class predicts each translation from its own copy of the TLB and page
// map, and compares the results in order while both channels idle at random.
module tb_top;
  import tlbpt_pkg::*;

  localparam int TLB_SLOTS        = 16;
  localparam int PAGES            = 256;
  localparam int FRAMES           = 256;
  localparam int OFS_W            = 8;
  localparam int RANDOM_REQUESTS  = 1800;
  localparam int LONG_HOLD_AT     = 700;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct {
    logic [ADDR_WIDTH-1:0]  phys;
    tlbpt_outcome_t         oc;
    logic [TOTAL_WIDTH-1:0] hits;
    logic [TOTAL_WIDTH-1:0] faults;
  } translation_t;

  class translation_tracker;
    bit                     map_valid[PAGES];
    int                     map_frame[PAGES];
    bit                     tlb_valid[TLB_SLOTS];
    int                     tlb_page[TLB_SLOTS];
    int                     tlb_frame[TLB_SLOTS];
    int                     insert_slot;
    int                     frames_used;
    logic [TOTAL_WIDTH-1:0] hit_count;
    logic [TOTAL_WIDTH-1:0] fault_count;
    translation_t           pending_translations[$];
    int                     mismatches;

    function new();
      insert_slot = 0;
      frames_used = 0;
      hit_count   = '0;
      fault_count = '0;
      mismatches  = 0;
    endfunction

    function void fill_tlb(int page, int frame);
      tlb_valid[insert_slot] = 1'b1;
      tlb_page[insert_slot]  = page;
      tlb_frame[insert_slot] = frame;
      insert_slot = (insert_slot + 1) % TLB_SLOTS;
    endfunction

    function void note_request(logic [ADDR_WIDTH-1:0] addr);
      translation_t t;
      int           page;
      int           offset;
      int           frame;
      bit           found;
      offset = addr & ((1 << OFS_W) - 1);
      page   = (addr >> OFS_W) % PAGES;
      frame  = 0;
      found  = 1'b0;
      for (int i = 0; i < TLB_SLOTS; i++) begin
        if (!found && tlb_valid[i] && tlb_page[i] == page) begin
          found = 1'b1;
          frame = tlb_frame[i];
        end
      end
      if (found) begin
        hit_count++;
        t.oc = OC_TLB_HIT;
      end else if (map_valid[page]) begin
        frame = map_frame[page];
        t.oc  = OC_MAP_HIT;
        fill_tlb(page, frame);
      end else if (frames_used < FRAMES) begin
        frame = frames_used;
        frames_used++;
        map_valid[page] = 1'b1;
        map_frame[page] = frame;
        fault_count++;
        t.oc = OC_FAULT;
        fill_tlb(page, frame);
      end else begin
        t.oc = OC_NO_FRAME;
      end
      t.phys   = (t.oc == OC_NO_FRAME) ? '0 : ADDR_WIDTH'((frame << OFS_W) | offset);
      t.hits   = hit_count;
      t.faults = fault_count;
      pending_translations.push_back(t);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [ADDR_WIDTH-1:0] phys, logic [OUTCOME_WIDTH-1:0] oc,
                      logic [TOTAL_WIDTH-1:0] hits, logic [TOTAL_WIDTH-1:0] faults);
      translation_t t;
      if (pending_translations.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        t = pending_translations.pop_front();
        if (phys !== t.phys)
          report_mismatch($sformatf("phys_addr %h, expected %h", phys, t.phys));
        if (oc !== t.oc)
          report_mismatch($sformatf("outcome %0d, expected %s", oc, t.oc.name()));
        if (hits !== t.hits)
          report_mismatch($sformatf("tlb_hit_total %0d, expected %0d", hits, t.hits));
        if (faults !== t.faults)
          report_mismatch($sformatf("fault_total %0d, expected %0d", faults, t.faults));
      end
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [ADDR_WIDTH-1:0]    virt_addr = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [ADDR_WIDTH-1:0]    phys_addr;
  logic [OUTCOME_WIDTH-1:0] outcome;
  logic [TOTAL_WIDTH-1:0]   tlb_hit_total;
  logic [TOTAL_WIDTH-1:0]   fault_total;

  translation_tracker tracker = new();
  int                 send_idle_max = 18;
  int                 recv_idle_max = 18;

  tlb_page_table_translator #(
    .TLB_ENTRIES (TLB_SLOTS),
    .PAGE_COUNT  (PAGES),
    .FRAME_COUNT (FRAMES),
    .OFFSET_WIDTH(OFS_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .virt_addr    (virt_addr),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .phys_addr    (phys_addr),
    .outcome      (outcome),
    .tlb_hit_total(tlb_hit_total),
    .fault_total  (fault_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_choice();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 18;
    endcase
  endfunction

  task automatic send_request(input logic [ADDR_WIDTH-1:0] addr);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    virt_addr <= addr;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_request(addr);
    @(negedge clk);
  endtask

  initial begin : request_side
    logic [ADDR_WIDTH-1:0] addr;
    int                    page;
    int                    pick;
    int                    recent[$];
    int                    touched[$];
    bit                    seen[PAGES];
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_request(16'h0000);
    send_request(16'h00FF);
    send_request(16'hFFFF);
    send_request(16'hFF00);
    send_request(16'h8001);
    for (int p = 1; p <= 16; p++) begin
      send_request(ADDR_WIDTH'((p << OFS_W) | ((p % 2) ? 8'hA5 : 8'h5A)));
    end
    send_request(16'h0012);
    send_request(16'h0034);
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 0) send_idle_max = idle_choice();
      pick = $urandom_range(0, 99);
      if (pick < 55 && recent.size() > 0) begin
        page = recent[$urandom_range(0, recent.size() - 1)];
        addr = ADDR_WIDTH'((page << OFS_W) | $urandom_range(0, (1 << OFS_W) - 1));
      end else if (pick < 80 && touched.size() > 0) begin
        page = touched[$urandom_range(0, touched.size() - 1)];
        addr = ADDR_WIDTH'((page << OFS_W) | $urandom_range(0, (1 << OFS_W) - 1));
      end else begin
        addr = ADDR_WIDTH'($urandom_range(0, (1 << ADDR_WIDTH) - 1));
      end
      page = (addr >> OFS_W) % PAGES;
      recent.push_back(page);
      if (recent.size() > 10) void'(recent.pop_front());
      if (!seen[page]) begin
        seen[page] = 1'b1;
        touched.push_back(page);
      end
      send_request(addr);
    end
    in_valid <= 1'b0;
    while (tracker.pending_translations.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : result_side
    int hold;
    int taken;
    taken = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      hold = (taken == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : $urandom_range(0, recv_idle_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_result(phys_addr, outcome, tlb_hit_total, fault_total);
      taken++;
      if (taken % 150 == 0) recv_idle_max = idle_choice();
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #1000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
